FILE: sv/lrd_pkg.sv
// ----------------------------------------------------------------------------
// lrd_pkg
// Shared types, codes and the CRC-32C byte update for the record deframer.
// ----------------------------------------------------------------------------
package lrd_pkg;

    localparam int HDR_BYTES  = 24;
    localparam int CRC_SPAN   = 20;
    localparam int Q_DEPTH    = 4;
    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    localparam logic [2:0] ERR_TRUNC    = 3'd0;
    localparam logic [2:0] ERR_MAGIC    = 3'd1;
    localparam logic [2:0] ERR_VERSION  = 3'd2;
    localparam logic [2:0] ERR_OPCODE   = 3'd3;
    localparam logic [2:0] ERR_SIZE     = 3'd4;
    localparam logic [2:0] ERR_CRC      = 3'd5;

    localparam logic [2:0] REG_MAGIC    = 3'd0;
    localparam logic [2:0] REG_VERSION  = 3'd1;
    localparam logic [2:0] REG_PUT      = 3'd2;
    localparam logic [2:0] REG_DELETE   = 3'd3;
    localparam logic [2:0] REG_KEY_LIM  = 3'd4;
    localparam logic [2:0] REG_VAL_LIM  = 3'd5;
    localparam logic [2:0] REG_RID_LIM  = 3'd6;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_KEY,
        PH_VALUE,
        PH_REQID
    } t_phase;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [15:0] format_version;
        logic [7:0]  put_code;
        logic [7:0]  delete_code;
        logic [10:0] key_limit;
        logic [20:0] value_limit;
        logic [12:0] request_id_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  part;
        logic [7:0]  data_byte;
        logic        operation;
        logic [2:0]  err_code;
        logic [31:0] rec_index;
        logic        last;
    } t_result;

    typedef struct packed {
        t_result r0;
        t_result r1;
        logic    two;
    } t_packet;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: sv/log_record_deframer_crc32c.sv
// ----------------------------------------------------------------------------
// log_record_deframer_crc32c
// Splits a log byte stream into CRC-32C checked records.
// ----------------------------------------------------------------------------
// One stream word is taken per clock while the queue is not full. Header
// bytes give no output until the 24th, payload bytes come out one per word
// tagged with their part, and the last payload byte of a record also yields
// the verdict, so that word yields two results; a four-packet queue between
// the front end and the output stage absorbs this and output stalls. The
// CRC-32C update and length compare run in the same cycle as the byte. After
// an error, words are swallowed until an end-of-stream word. Registers sit
// on an APB port at byte addresses 0x00..0x18.
module log_record_deframer_crc32c #(
    parameter int COUNT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_byte_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_part,
    output logic [7:0]  o_data_byte,
    output logic        o_operation,
    output logic [2:0]  o_err_code,
    output logic [31:0] o_rec_index,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lrd_pkg::t_cfg    r_cfg;
    lrd_pkg::t_packet w_packet, w_q_packet;
    lrd_pkg::t_result w_result;
    logic w_push, w_full, w_q_valid, w_pop, w_take, w_wr;

    assign pready  = 1'b1;
    assign o_ready = !w_full;
    assign w_take  = i_valid && o_ready;
    assign w_wr    = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_word       <= 32'd0;
            r_cfg.format_version   <= 16'd1;
            r_cfg.put_code         <= 8'd0;
            r_cfg.delete_code      <= 8'd1;
            r_cfg.key_limit        <= 11'd1024;
            r_cfg.value_limit      <= 21'd1048576;
            r_cfg.request_id_limit <= 13'd4096;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                lrd_pkg::REG_MAGIC:   r_cfg.magic_word       <= pwdata;
                lrd_pkg::REG_VERSION: r_cfg.format_version   <= pwdata[15:0];
                lrd_pkg::REG_PUT:     r_cfg.put_code         <= pwdata[7:0];
                lrd_pkg::REG_DELETE:  r_cfg.delete_code      <= pwdata[7:0];
                lrd_pkg::REG_KEY_LIM: r_cfg.key_limit        <= pwdata[10:0];
                lrd_pkg::REG_VAL_LIM: r_cfg.value_limit      <= pwdata[20:0];
                lrd_pkg::REG_RID_LIM: r_cfg.request_id_limit <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            lrd_pkg::REG_MAGIC:   prdata = r_cfg.magic_word;
            lrd_pkg::REG_VERSION: prdata = 32'(r_cfg.format_version);
            lrd_pkg::REG_PUT:     prdata = 32'(r_cfg.put_code);
            lrd_pkg::REG_DELETE:  prdata = 32'(r_cfg.delete_code);
            lrd_pkg::REG_KEY_LIM: prdata = 32'(r_cfg.key_limit);
            lrd_pkg::REG_VAL_LIM: prdata = 32'(r_cfg.value_limit);
            lrd_pkg::REG_RID_LIM: prdata = 32'(r_cfg.request_id_limit);
            default:              prdata = 32'd0;
        endcase
    end

    lrd_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (w_take),
        .i_op         (i_op),
        .i_byte_value (i_byte_value),
        .i_cfg        (r_cfg),
        .o_push       (w_push),
        .o_packet     (w_packet)
    );

    lrd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_packet (w_packet),
        .i_pop    (w_pop),
        .o_full   (w_full),
        .o_valid  (w_q_valid),
        .o_packet (w_q_packet)
    );

    lrd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_packet (w_q_packet),
        .o_pop      (w_pop),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_result   (w_result)
    );

    assign o_kind       = w_result.kind;
    assign o_part       = w_result.part;
    assign o_data_byte  = w_result.data_byte;
    assign o_operation  = w_result.operation;
    assign o_err_code   = w_result.err_code;
    assign o_rec_index  = w_result.rec_index;
    assign o_last       = w_result.last;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full) else $error("queue overflow");

    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != lrd_pkg::KIND_PAYLOAD |-> o_last)
        else $error("verdict not last");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid) else $error("pop from empty queue");
`endif

endmodule

FILE: sv/lrd_front.sv
// ----------------------------------------------------------------------------
// lrd_front
// Takes stream words, tracks header and payload phases, runs the CRC and
// builds result packets of one or two results.
// ----------------------------------------------------------------------------
module lrd_front #(
    parameter int COUNT_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic              i_op,
    input  logic [7:0]        i_byte_value,
    input  lrd_pkg::t_cfg     i_cfg,
    output logic              o_push,
    output lrd_pkg::t_packet  o_packet
);

    lrd_pkg::t_phase          r_phase, n_phase;
    logic [7:0]               r_hdr [lrd_pkg::HDR_BYTES];
    logic [20:0]              r_count, n_count;
    logic [31:0]              r_crc, n_crc;
    logic [COUNT_BITS-1:0]    r_records, n_records;
    logic                     r_halted, n_halted;

    logic [31:0] w_crc_b, w_magic, w_klen, w_vlen, w_rlen, w_cur_len, w_crc_final;
    logic [31:0] w_crc_want, w_index;
    logic [15:0] w_version;
    logic [2:0]  w_nz;
    logic [2:0]  w_hdr_err;
    logic        w_hdr_bad, w_hdr_last, w_pay_done, w_step_done, w_more, w_match, w_rec_op;
    logic [21:0] w_count_inc;
    lrd_pkg::t_phase w_next;

    assign w_crc_b   = lrd_pkg::crc_byte(r_crc, i_byte_value);
    assign w_magic   = {r_hdr[3], r_hdr[2], r_hdr[1], r_hdr[0]};
    assign w_version = {r_hdr[5], r_hdr[4]};
    assign w_klen    = {r_hdr[11], r_hdr[10], r_hdr[9], r_hdr[8]};
    assign w_vlen    = {r_hdr[15], r_hdr[14], r_hdr[13], r_hdr[12]};
    assign w_rlen    = {r_hdr[19], r_hdr[18], r_hdr[17], r_hdr[16]};
    assign w_nz      = {w_rlen != 32'd0, w_vlen != 32'd0, w_klen != 32'd0};
    assign w_rec_op  = (r_hdr[6] == i_cfg.put_code) ? 1'b0 : 1'b1;
    assign w_index   = 32'(r_records);

    assign w_hdr_last  = (r_phase == lrd_pkg::PH_HEADER) &&
                         (r_count == 21'(lrd_pkg::HDR_BYTES - 1));
    assign w_count_inc = {1'b0, r_count} + 22'd1;

    always_comb begin
        unique case (r_phase)
            lrd_pkg::PH_KEY:   w_cur_len = w_klen;
            lrd_pkg::PH_VALUE: w_cur_len = w_vlen;
            default:           w_cur_len = w_rlen;
        endcase
    end
    assign w_pay_done = 32'(w_count_inc) >= w_cur_len;

    always_comb begin
        w_hdr_err = lrd_pkg::ERR_TRUNC;
        w_hdr_bad = 1'b1;
        priority if (w_magic != i_cfg.magic_word) begin
            w_hdr_err = lrd_pkg::ERR_MAGIC;
        end else if (w_version != i_cfg.format_version) begin
            w_hdr_err = lrd_pkg::ERR_VERSION;
        end else if (r_hdr[6] != i_cfg.put_code && r_hdr[6] != i_cfg.delete_code) begin
            w_hdr_err = lrd_pkg::ERR_OPCODE;
        end else if (w_klen > 32'(i_cfg.key_limit) || w_vlen > 32'(i_cfg.value_limit) ||
                     w_rlen > 32'(i_cfg.request_id_limit)) begin
            w_hdr_err = lrd_pkg::ERR_SIZE;
        end else begin
            w_hdr_bad = 1'b0;
        end
    end

    // next non-empty part after the current phase
    always_comb begin
        w_more = 1'b1;
        w_next = lrd_pkg::PH_HEADER;
        priority if (r_phase == lrd_pkg::PH_HEADER && w_nz[0]) begin
            w_next = lrd_pkg::PH_KEY;
        end else if ((r_phase == lrd_pkg::PH_HEADER || r_phase == lrd_pkg::PH_KEY) &&
                     w_nz[1]) begin
            w_next = lrd_pkg::PH_VALUE;
        end else if (r_phase != lrd_pkg::PH_REQID && w_nz[2]) begin
            w_next = lrd_pkg::PH_REQID;
        end else begin
            w_more = 1'b0;
        end
    end

    assign w_crc_final = (r_phase == lrd_pkg::PH_HEADER) ? r_crc : w_crc_b;
    assign w_crc_want  = (r_phase == lrd_pkg::PH_HEADER) ?
                         {i_byte_value, r_hdr[22], r_hdr[21], r_hdr[20]} :
                         {r_hdr[23], r_hdr[22], r_hdr[21], r_hdr[20]};
    assign w_match     = ~w_crc_final == w_crc_want;
    assign w_step_done = (w_hdr_last && !w_hdr_bad) ||
                         (r_phase != lrd_pkg::PH_HEADER && w_pay_done);

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_crc     = r_crc;
        n_records = r_records;
        n_halted  = r_halted;
        if (i_take) begin
            if (i_op == lrd_pkg::OP_END) begin
                n_phase   = lrd_pkg::PH_HEADER;
                n_count   = '0;
                n_crc     = '1;
                n_records = '0;
                n_halted  = 1'b0;
            end else if (!r_halted) begin
                if (r_phase == lrd_pkg::PH_HEADER) begin
                    if (r_count < 21'(lrd_pkg::CRC_SPAN)) begin
                        n_crc = w_crc_b;
                    end
                    n_count = w_count_inc[20:0];
                    if (w_hdr_last && w_hdr_bad) begin
                        n_halted = 1'b1;
                    end
                end else begin
                    n_crc   = w_crc_b;
                    n_count = w_count_inc[20:0];
                end
                if (w_step_done) begin
                    n_count = '0;
                    if (w_more) begin
                        n_phase = w_next;
                    end else if (w_match) begin
                        n_phase   = lrd_pkg::PH_HEADER;
                        n_crc     = '1;
                        n_records = r_records + COUNT_BITS'(1);
                    end else begin
                        n_halted = 1'b1;
                    end
                end
            end
        end
    end

    // outputs
    always_comb begin
        lrd_pkg::t_result v;
        o_push   = 1'b0;
        o_packet = '0;
        v        = '0;
        v.rec_index = w_index;
        if (!w_more) begin
            if (w_match) begin
                v.kind      = lrd_pkg::KIND_ACCEPT;
                v.operation = w_rec_op;
            end else begin
                v.kind     = lrd_pkg::KIND_ERROR;
                v.err_code = lrd_pkg::ERR_CRC;
            end
        end
        v.last = 1'b1;
        if (i_take) begin
            if (i_op == lrd_pkg::OP_END) begin
                o_push                 = !r_halted;
                o_packet.r0.rec_index  = w_index;
                o_packet.r0.last       = 1'b1;
                o_packet.r0.kind       = (r_phase == lrd_pkg::PH_HEADER && r_count == '0) ?
                                         lrd_pkg::KIND_END : lrd_pkg::KIND_ERROR;
            end else if (!r_halted) begin
                if (r_phase == lrd_pkg::PH_HEADER) begin
                    if (w_hdr_last) begin
                        o_push = 1'b1;
                        if (w_hdr_bad) begin
                            o_packet.r0.kind      = lrd_pkg::KIND_ERROR;
                            o_packet.r0.err_code  = w_hdr_err;
                            o_packet.r0.rec_index = w_index;
                            o_packet.r0.last      = 1'b1;
                        end else if (!w_more) begin
                            o_packet.r0 = v;
                        end else begin
                            o_push = 1'b0;
                        end
                    end
                end else begin
                    o_push                = 1'b1;
                    o_packet.r0.kind      = lrd_pkg::KIND_PAYLOAD;
                    o_packet.r0.part      = 2'(r_phase) - 2'd1;
                    o_packet.r0.data_byte = i_byte_value;
                    o_packet.r0.operation = w_rec_op;
                    o_packet.r0.rec_index = w_index;
                    o_packet.r0.last      = !(w_pay_done && !w_more);
                    if (w_pay_done && !w_more) begin
                        o_packet.r1  = v;
                        o_packet.two = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= lrd_pkg::PH_HEADER;
            r_count   <= '0;
            r_crc     <= '1;
            r_records <= '0;
            r_halted  <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_crc     <= n_crc;
            r_records <= n_records;
            r_halted  <= n_halted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_op == lrd_pkg::OP_BYTE && !r_halted &&
            r_phase == lrd_pkg::PH_HEADER) begin
            r_hdr[r_count[4:0]] <= i_byte_value;
        end
    end

endmodule

FILE: sv/lrd_queue.sv
// ----------------------------------------------------------------------------
// lrd_queue
// Small packet queue between the front and the back end.
// ----------------------------------------------------------------------------
module lrd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lrd_pkg::t_packet  i_packet,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output lrd_pkg::t_packet  o_packet
);

    lrd_pkg::t_packet r_mem [lrd_pkg::Q_DEPTH];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt, n_cnt;

    assign o_full   = r_cnt == 3'(lrd_pkg::Q_DEPTH);
    assign o_valid  = r_cnt != 3'd0;
    assign o_packet = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 3'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_packet;
        end
    end

endmodule

FILE: sv/lrd_back.sv
// ----------------------------------------------------------------------------
// lrd_back
// Unpacks queued packets into single results on a registered output.
// ----------------------------------------------------------------------------
module lrd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  lrd_pkg::t_packet  i_q_packet,
    output logic              o_pop,
    input  logic              i_ready,
    output logic              o_valid,
    output lrd_pkg::t_result  o_result
);

    logic             r_valid, r_pend;
    lrd_pkg::t_result r_out, r_second;
    logic             w_load;

    assign w_load   = !r_valid || i_ready;
    assign o_pop    = w_load && !r_pend && i_q_valid;
    assign o_valid  = r_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (w_load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else begin
                r_valid <= i_q_valid;
                r_pend  <= i_q_valid && i_q_packet.two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_pend) begin
                r_out <= r_second;
            end else begin
                r_out    <= i_q_packet.r0;
                r_second <= i_q_packet.r1;
            end
        end
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the record deframer: builds CRC-32C framed records
// (good, corrupt, truncated, bad header), predicts every output word and
// compares them against the block under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct {
        logic       op;
        logic [7:0] b;
    } t_in;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_op = 1'b0;
    logic [7:0]  i_byte_value = 8'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [1:0]  o_part;
    logic [7:0]  o_data_byte;
    logic        o_operation;
    logic [2:0]  o_err_code;
    logic [31:0] o_rec_index;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = 5'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    log_record_deframer_crc32c DUT (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    lrd_pkg::t_cfg   cfg;
    lrd_pkg::t_phase ph;
    logic [7:0]  hdr [lrd_pkg::HDR_BYTES];
    logic [31:0] cnt;
    logic [31:0] crc;
    logic [31:0] recs;
    logic        halted;

    t_in              word_q [$];
    lrd_pkg::t_result result_q [$];
    int      errors = 0;
    int      n_results = 0;
    int      n_records = 0;
    longint  cycles = 0;
    bit      hold_start = 1'b0;
    bit      in_taken = 1'b0;

    function automatic logic [31:0] le32(int at);
        return {hdr[at+3], hdr[at+2], hdr[at+1], hdr[at]};
    endfunction

    function automatic logic [31:0] crc_upd(logic [31:0] c, logic [7:0] b);
        c ^= {24'd0, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ 32'h82F63B78) : (c >> 1);
        return c;
    endfunction

    function automatic logic [31:0] part_len(lrd_pkg::t_phase p);
        case (p)
            lrd_pkg::PH_KEY:   return le32(8);
            lrd_pkg::PH_VALUE: return le32(12);
            lrd_pkg::PH_REQID: return le32(16);
            default:           return 0;
        endcase
    endfunction

    task automatic stream_clear();
        ph = lrd_pkg::PH_HEADER;
        cnt = 0;
        crc = '1;
        recs = 0;
        halted = 1'b0;
        foreach (hdr[i]) hdr[i] = 8'd0;
    endtask

    task automatic push_result(logic [1:0] kind, logic [1:0] part, logic [7:0] d,
                               logic opn, logic [2:0] err);
        lrd_pkg::t_result r;
        r.kind = kind; r.part = part; r.data_byte = d; r.operation = opn;
        r.err_code = err; r.rec_index = recs; r.last = 1'b0;
        result_q = {result_q, r};
    endtask

    function automatic logic rec_op();
        return (hdr[6] == cfg.put_code) ? 1'b0 : 1'b1;
    endfunction

    task automatic next_part(lrd_pkg::t_phase from);
        int p;
        p = int'(from) + 1;
        while (p <= 3 && part_len(lrd_pkg::t_phase'(p)) == 0) p++;
        cnt = 0;
        if (p <= 3) begin
            ph = lrd_pkg::t_phase'(p);
        end else if (~crc == le32(20)) begin
            push_result(lrd_pkg::KIND_ACCEPT, 2'd0, 8'd0, rec_op(), lrd_pkg::ERR_TRUNC);
            recs++;
            n_records++;
            ph = lrd_pkg::PH_HEADER;
            crc = '1;
        end else begin
            push_result(lrd_pkg::KIND_ERROR, 2'd0, 8'd0, 1'b0, lrd_pkg::ERR_CRC);
            halted = 1'b1;
        end
    endtask

    task automatic predict_word(t_in w);
        int n0;
        logic [2:0] err;
        bit bad;
        n0 = result_q.size();
        if (w.op == lrd_pkg::OP_END) begin
            if (!halted) begin
                if (ph == lrd_pkg::PH_HEADER && cnt == 0)
                    push_result(lrd_pkg::KIND_END, 2'd0, 8'd0, 1'b0, lrd_pkg::ERR_TRUNC);
                else
                    push_result(lrd_pkg::KIND_ERROR, 2'd0, 8'd0, 1'b0, lrd_pkg::ERR_TRUNC);
            end
            stream_clear();
        end else if (!halted) begin
            if (ph == lrd_pkg::PH_HEADER) begin
                hdr[cnt] = w.b;
                if (cnt < lrd_pkg::CRC_SPAN) crc = crc_upd(crc, w.b);
                cnt++;
                if (cnt == lrd_pkg::HDR_BYTES) begin
                    bad = 1'b1;
                    if (le32(0) != cfg.magic_word) err = lrd_pkg::ERR_MAGIC;
                    else if ({hdr[5], hdr[4]} != cfg.format_version)
                        err = lrd_pkg::ERR_VERSION;
                    else if (hdr[6] != cfg.put_code && hdr[6] != cfg.delete_code)
                        err = lrd_pkg::ERR_OPCODE;
                    else if (le32(8) > cfg.key_limit || le32(12) > cfg.value_limit
                             || le32(16) > cfg.request_id_limit) err = lrd_pkg::ERR_SIZE;
                    else bad = 1'b0;
                    if (bad) begin
                        push_result(lrd_pkg::KIND_ERROR, 2'd0, 8'd0, 1'b0, err);
                        halted = 1'b1;
                    end else begin
                        next_part(lrd_pkg::PH_HEADER);
                    end
                end
            end else begin
                push_result(lrd_pkg::KIND_PAYLOAD, 2'(int'(ph) - 1), w.b, rec_op(),
                            lrd_pkg::ERR_TRUNC);
                crc = crc_upd(crc, w.b);
                cnt++;
                if (cnt >= part_len(ph)) next_part(ph);
            end
        end
        if (result_q.size() > n0) result_q[result_q.size()-1].last = 1'b1;
    endtask

    // driver: bursts and gaps
    int gap = 0;
    int burst = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_taken) begin
                predict_word(word_q.pop_front());
            end
            if (!i_valid || in_taken) begin
                if (gap > 0) begin
                    gap--;
                    i_valid <= 1'b0;
                end else if (word_q.size() > 0) begin
                    i_valid <= 1'b1;
                    i_op <= word_q[0].op;
                    i_byte_value <= word_q[0].b;
                    if (burst == 0) begin
                        burst = $urandom_range(1, 40);
                        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                    end else begin
                        burst--;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off counted here
    int stall_phase = 0;
    int hold_cnt = 0;
    always @(negedge i_clk) begin
        stall_phase = (stall_phase + 1) % 97;
        if (hold_start && hold_cnt < 300) begin
            hold_cnt++;
            i_ready <= 1'b0;
        end
        else if (stall_phase < 30) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(0, 2) != 0);
    end

    // monitor
    always @(posedge i_clk) begin
        cycles++;
        in_taken = i_rst_n && i_valid && o_ready;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (result_q.size() == 0) begin
                $error("unexpected result kind=%0d", o_kind);
                errors++;
            end else begin
                lrd_pkg::t_result e;
                e = result_q.pop_front();
                if (o_kind != e.kind) begin
                    $error("kind exp %0d got %0d", e.kind, o_kind); errors++;
                end
                if (o_part != e.part) begin
                    $error("part exp %0d got %0d", e.part, o_part); errors++;
                end
                if (o_data_byte != e.data_byte) begin
                    $error("data_byte exp %0h got %0h", e.data_byte, o_data_byte); errors++;
                end
                if (o_operation != e.operation) begin
                    $error("operation exp %0d got %0d", e.operation, o_operation); errors++;
                end
                if (o_err_code != e.err_code) begin
                    $error("err_code exp %0d got %0d", e.err_code, o_err_code);
                    errors++;
                end
                if (o_rec_index != e.rec_index) begin
                    $error("rec_index exp %0d got %0d", e.rec_index, o_rec_index);
                    errors++;
                end
                if (o_last != e.last) begin
                    $error("last exp %0d got %0d", e.last, o_last); errors++;
                end
            end
        end
        if (cycles > 400000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] v);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            lrd_pkg::REG_MAGIC:   cfg.magic_word = v;
            lrd_pkg::REG_VERSION: cfg.format_version = v[15:0];
            lrd_pkg::REG_PUT:     cfg.put_code = v[7:0];
            lrd_pkg::REG_DELETE:  cfg.delete_code = v[7:0];
            lrd_pkg::REG_KEY_LIM: cfg.key_limit = v[10:0];
            lrd_pkg::REG_VAL_LIM: cfg.value_limit = v[20:0];
            default:              cfg.request_id_limit = v[12:0];
        endcase
    endtask

    task automatic drain();
        while (word_q.size() > 0 || i_valid || result_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic put_byte(logic [7:0] b);
        t_in w;
        w.op = lrd_pkg::OP_BYTE; w.b = b;
        word_q = {word_q, w};
    endtask

    task automatic put_end();
        t_in w;
        w.op = lrd_pkg::OP_END; w.b = 8'($urandom);
        word_q = {word_q, w};
    endtask

    task automatic put_le(logic [31:0] v, int n, inout logic [31:0] c);
        for (int i = 0; i < n; i++) begin
            put_byte(v[8*i +: 8]);
            c = crc_upd(c, v[8*i +: 8]);
        end
    endtask

    // fault: 0 none, 1 magic, 2 version, 3 opcode, 4 size, 5 crc, 6 truncate
    task automatic put_record(int kl, int vl, int rl, logic [7:0] opc, int fault);
        logic [31:0] c;
        logic [31:0] fin;
        logic [7:0]  pay [$];
        int total;
        int cut;
        c = '1;
        total = 0;
        put_le(fault == 1 ? cfg.magic_word ^ (32'd1 << $urandom_range(0, 31))
                          : cfg.magic_word, 4, c);
        put_le(fault == 2 ? {16'd0, cfg.format_version ^ 16'(1 << $urandom_range(0, 15))}
                          : {16'd0, cfg.format_version}, 2, c);
        put_le({24'd0, fault == 3 ? 8'(cfg.put_code + cfg.delete_code + 8'd7) : opc}, 1, c);
        put_le({24'd0, 8'($urandom)}, 1, c);
        if (fault == 4) begin
            case ($urandom_range(0, 3))
                0: kl = cfg.key_limit + 1;
                1: vl = cfg.value_limit + 1;
                2: rl = cfg.request_id_limit + 1;
                default: kl = 32'hFFFF_FFFF;
            endcase
        end
        put_le(kl, 4, c);
        put_le(vl, 4, c);
        put_le(rl, 4, c);
        if (fault >= 1 && fault <= 4) begin
            put_le($urandom, 4, c);
            return;
        end
        total = kl + vl + rl;
        for (int i = 0; i < total; i++) begin
            pay = {pay, 8'($urandom)};
            c = crc_upd(c, pay[i]);
        end
        fin = ~c;
        if (fault == 5) fin ^= 32'd1 << $urandom_range(0, 31);
        cut = (fault == 6) ? $urandom_range(1, 4 + total - 1) : 4 + total;
        for (int i = 0; i < 4 && i < cut; i++) put_byte(fin[8*i +: 8]);
        for (int i = 0; i + 4 < cut; i++) put_byte(pay[i]);
        if (fault == 6) put_end();
    endtask

    task automatic random_records(int n);
        int f;
        for (int i = 0; i < n; i++) begin
            f = $urandom_range(0, 19);
            if (f > 6) f = 0;
            if ($urandom_range(0, 40) == 0) put_byte(8'($urandom));
            put_record($urandom_range(0, cfg.key_limit < 6 ? cfg.key_limit : 6),
                       $urandom_range(0, cfg.value_limit < 12 ? cfg.value_limit : 12),
                       $urandom_range(0, cfg.request_id_limit < 4 ? cfg.request_id_limit : 4),
                       $urandom_range(0, 1) ? cfg.put_code : cfg.delete_code, f);
            if (f >= 1 && f <= 5) begin
                repeat ($urandom_range(0, 3)) put_byte(8'($urandom));
                put_end();
            end else if ($urandom_range(0, 15) == 0) begin
                put_end();
            end
        end
        put_end();
    endtask

    initial begin
        cfg = '{32'd0, 16'd1, 8'd0, 8'd1, 11'd1024, 21'd1048576, 13'd4096};
        stream_clear();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty record, each fault, halted traffic
        put_end();
        put_record(0, 0, 0, cfg.put_code, 0);
        put_record(1, 2, 1, cfg.delete_code, 0);
        put_record(2, 0, 0, cfg.put_code, 6);
        put_end();
        put_record(0, 1, 0, cfg.put_code, 1);
        put_byte(8'hFF);
        put_end();
        put_record(0, 1, 0, cfg.put_code, 2);
        put_end();
        put_record(0, 1, 0, cfg.put_code, 3);
        put_end();
        put_record(0, 1, 0, cfg.put_code, 4);
        put_end();
        put_record(1, 0, 1, cfg.put_code, 5);
        put_end();
        put_byte(8'h00);
        put_end();
        drain();

        apb_write(lrd_pkg::REG_MAGIC, 32'hFFFF_FFFF);
        apb_write(lrd_pkg::REG_VERSION, 32'hFFFF);
        apb_write(lrd_pkg::REG_PUT, 32'd255);
        apb_write(lrd_pkg::REG_DELETE, 32'd255);
        apb_write(lrd_pkg::REG_KEY_LIM, 32'd3);
        apb_write(lrd_pkg::REG_VAL_LIM, 32'd0);
        apb_write(lrd_pkg::REG_RID_LIM, 32'd2);
        random_records(9);
        drain();

        apb_write(lrd_pkg::REG_MAGIC, 32'hA5C3_0F96);
        apb_write(lrd_pkg::REG_VERSION, 32'd0);
        apb_write(lrd_pkg::REG_PUT, 32'd0);
        apb_write(lrd_pkg::REG_DELETE, 32'd128);
        apb_write(lrd_pkg::REG_KEY_LIM, 32'd2047);
        apb_write(lrd_pkg::REG_VAL_LIM, 32'h1F_FFFF);
        apb_write(lrd_pkg::REG_RID_LIM, 32'h1FFF);
        // long hold-off while the sender keeps pushing
        hold_start = 1'b1;
        random_records(16);
        drain();

        apb_write(lrd_pkg::REG_MAGIC, $urandom);
        apb_write(lrd_pkg::REG_VERSION, $urandom);
        apb_write(lrd_pkg::REG_PUT, 32'd17);
        apb_write(lrd_pkg::REG_DELETE, 32'd200);
        apb_write(lrd_pkg::REG_KEY_LIM, 32'd0);
        apb_write(lrd_pkg::REG_VAL_LIM, 32'd8);
        apb_write(lrd_pkg::REG_RID_LIM, 32'd0);
        random_records(5);
        drain();

        apb_write(lrd_pkg::REG_KEY_LIM, 32'd1024);
        apb_write(lrd_pkg::REG_VAL_LIM, 32'd1048576);
        apb_write(lrd_pkg::REG_RID_LIM, 32'd4096);
        random_records(16);
        drain();

        $display("Checked %0d output words, %0d accepted records, across five register sets.",
                 n_results, n_records);
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
